// ===== rtl/prfl_pkg.sv =====
// Shared widths, register indexes and types for the FIFO/LRU page replacement core.
// Used by prfl_div and page_replacement_fifo_lru_core; depends on nothing.
package prfl_pkg;

  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned PAGE_W   = 10;
  localparam int unsigned PSIZE_W  = 7;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned FAULT_W  = 16;
  localparam int unsigned FRAME_W  = 2;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 7'd10;
  localparam logic [AGE_W-1:0]   AGE_MAX       = 16'hFFFF;
  localparam logic [FAULT_W-1:0] FAULT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [PSIZE_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/prfl_div.sv =====
// Restoring divider that turns an address into a page number, one quotient bit per cycle.
// Depends on prfl_pkg for widths and the request struct.
module prfl_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  prfl_pkg::div_req_t           req_i,
  output logic                         done_o,
  output logic [prfl_pkg::PAGE_W-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(prfl_pkg::ADDR_W);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [prfl_pkg::PSIZE_W-1:0]   div_q, div_d;
  logic [prfl_pkg::PSIZE_W-1:0]   rem_q, rem_d;
  logic [prfl_pkg::ADDR_W-1:0]    quo_q, quo_d;
  logic [prfl_pkg::PSIZE_W:0]     trial;
  logic                           take;

  assign trial = {rem_q, quo_q[prfl_pkg::ADDR_W-1]};
  assign take  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = take ? prfl_pkg::PSIZE_W'(trial - {1'b0, div_q})
                   : prfl_pkg::PSIZE_W'(trial);
      quo_d = {quo_q[prfl_pkg::ADDR_W-2:0], take};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(prfl_pkg::ADDR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = prfl_pkg::PAGE_W'(quo_q);

endmodule

// ===== rtl/page_replacement_fifo_lru_core.sv =====
// Top level of the FIFO/LRU page replacement core: frame table, scan sequencer and output word.
// Depends on prfl_pkg and instantiates prfl_div.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   address_i
//   out       output     out_valid_o / out_ready_i hit_o, frame_o, page_o, evicted_*, fault_count_o
//   cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// From acceptance, a word passes through the bit-serial divider, the one-frame-per-cycle scan
// and the update step before the output word is loaded.
// The core takes a new input word only while its sequencer is idle.
// A finished word waits in the output register; the next word then stalls in the update step.
// Reset clears the frame table, ages, pointer and fault counter at once; no sweep follows.
module page_replacement_fifo_lru_core #(
  parameter int unsigned FRAMES = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [prfl_pkg::ADDR_W-1:0]      address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [prfl_pkg::FRAME_W-1:0]     frame_o,
  output logic [prfl_pkg::PAGE_W-1:0]      page_o,
  output logic                             evicted_valid_o,
  output logic [prfl_pkg::PAGE_W-1:0]      evicted_page_o,
  output logic [prfl_pkg::FAULT_W-1:0]     fault_count_o,
  input  logic                             cfg_we_i,
  input  logic [prfl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [prfl_pkg::CFG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned FiW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic                           mode_q;
  logic [prfl_pkg::PSIZE_W-1:0]   page_size_q;

  logic [prfl_pkg::PAGE_W-1:0]    frame_page_q [FRAMES];
  logic [prfl_pkg::PAGE_W-1:0]    frame_page_d [FRAMES];
  logic [FRAMES-1:0]              frame_valid_q, frame_valid_d;
  logic [prfl_pkg::AGE_W-1:0]     frame_age_q [FRAMES];
  logic [prfl_pkg::AGE_W-1:0]     frame_age_d [FRAMES];
  logic [FiW-1:0]                 ptr_q, ptr_d;
  logic [prfl_pkg::FAULT_W-1:0]   faults_q, faults_d;

  logic [prfl_pkg::PAGE_W-1:0]    page_q, page_d;
  logic [FiW-1:0]                 scan_idx_q, scan_idx_d;
  logic                           hit_found_q, hit_found_d;
  logic [FiW-1:0]                 hit_idx_q, hit_idx_d;
  logic                           empty_found_q, empty_found_d;
  logic [FiW-1:0]                 empty_idx_q, empty_idx_d;
  logic [prfl_pkg::AGE_W-1:0]     best_age_q, best_age_d;
  logic [FiW-1:0]                 best_idx_q, best_idx_d;
  logic [prfl_pkg::PAGE_W-1:0]    best_page_q, best_page_d;
  logic [prfl_pkg::PAGE_W-1:0]    ptr_page_q, ptr_page_d;

  logic                           out_valid_q, out_valid_d;
  logic                           hit_q, hit_d;
  logic [FiW-1:0]                 frame_q, frame_d;
  logic [prfl_pkg::PAGE_W-1:0]    out_page_q, out_page_d;
  logic                           ev_valid_q, ev_valid_d;
  logic [prfl_pkg::PAGE_W-1:0]    ev_page_q, ev_page_d;

  prfl_pkg::div_req_t             div_req;
  logic                           div_done;
  logic [prfl_pkg::PAGE_W-1:0]    div_quo;
  logic                           in_fire;
  logic                           scan_last;
  logic                           can_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_last  = (scan_idx_q == FiW'(FRAMES - 1));
  assign can_load   = !out_valid_q || out_ready_i;

  assign div_req.start    = in_fire;
  assign div_req.dividend = address_i;
  assign div_req.divisor  = (page_size_q == '0) ? prfl_pkg::PSIZE_W'(1) : page_size_q;

  prfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    logic [FiW-1:0] used;
    state_d       = state_q;
    frame_page_d  = frame_page_q;
    frame_valid_d = frame_valid_q;
    frame_age_d   = frame_age_q;
    ptr_d         = ptr_q;
    faults_d      = faults_q;
    page_d        = page_q;
    scan_idx_d    = scan_idx_q;
    hit_found_d   = hit_found_q;
    hit_idx_d     = hit_idx_q;
    empty_found_d = empty_found_q;
    empty_idx_d   = empty_idx_q;
    best_age_d    = best_age_q;
    best_idx_d    = best_idx_q;
    best_page_d   = best_page_q;
    ptr_page_d    = ptr_page_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    hit_d         = hit_q;
    frame_d       = frame_q;
    out_page_d    = out_page_q;
    ev_valid_d    = ev_valid_q;
    ev_page_d     = ev_page_q;
    used          = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          page_d        = div_quo;
          scan_idx_d    = '0;
          hit_found_d   = 1'b0;
          empty_found_d = 1'b0;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // One frame per cycle through the shared compare logic.
        if (!hit_found_q && frame_valid_q[scan_idx_q]
            && frame_page_q[scan_idx_q] == page_q) begin
          hit_found_d = 1'b1;
          hit_idx_d   = scan_idx_q;
        end
        if (!empty_found_q && !frame_valid_q[scan_idx_q]) begin
          empty_found_d = 1'b1;
          empty_idx_d   = scan_idx_q;
        end
        if (scan_idx_q == '0 || frame_age_q[scan_idx_q] > best_age_q) begin
          best_age_d  = frame_age_q[scan_idx_q];
          best_idx_d  = scan_idx_q;
          best_page_d = frame_page_q[scan_idx_q];
        end
        if (scan_idx_q == ptr_q) begin
          ptr_page_d = frame_page_q[scan_idx_q];
        end
        if (scan_last) begin
          state_d = ST_UPD;
        end else begin
          scan_idx_d = scan_idx_q + FiW'(1);
        end
      end
      ST_UPD: begin
        if (can_load) begin
          ev_valid_d = 1'b0;
          ev_page_d  = '0;
          if (hit_found_q) begin
            used = hit_idx_q;
          end else begin
            if (faults_q != prfl_pkg::FAULT_MAX) begin
              faults_d = faults_q + prfl_pkg::FAULT_W'(1);
            end
            if (empty_found_q) begin
              used = empty_idx_q;
              frame_valid_d[used] = 1'b1;
              frame_page_d[used]  = page_q;
            end else begin
              if (mode_q == prfl_pkg::MODE_LRU) begin
                used      = best_idx_q;
                ev_page_d = best_page_q;
              end else begin
                used      = ptr_q;
                ev_page_d = ptr_page_q;
                ptr_d     = (ptr_q == FiW'(FRAMES - 1)) ? '0 : ptr_q + FiW'(1);
              end
              ev_valid_d         = 1'b1;
              frame_page_d[used] = page_q;
            end
          end
          if (mode_q == prfl_pkg::MODE_LRU) begin
            // On eviction every other frame ages; otherwise only the other valid frames.
            for (int unsigned j = 0; j < FRAMES; j++) begin
              if ((frame_valid_q[j] || (!hit_found_q && !empty_found_q))
                  && frame_age_q[j] != prfl_pkg::AGE_MAX) begin
                frame_age_d[j] = frame_age_q[j] + prfl_pkg::AGE_W'(1);
              end
            end
            frame_age_d[used] = '0;
          end
          hit_d       = hit_found_q;
          frame_d     = used;
          out_page_d  = page_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= prfl_pkg::MODE_FIFO;
      page_size_q   <= prfl_pkg::PAGE_SIZE_RST;
      frame_valid_q <= '0;
      ptr_q         <= '0;
      faults_q      <= '0;
      out_valid_q   <= 1'b0;
      for (int unsigned i = 0; i < FRAMES; i++) begin
        frame_page_q[i] <= '0;
        frame_age_q[i]  <= '0;
      end
    end else begin
      state_q       <= state_d;
      frame_valid_q <= frame_valid_d;
      ptr_q         <= ptr_d;
      faults_q      <= faults_d;
      out_valid_q   <= out_valid_d;
      frame_page_q  <= frame_page_d;
      frame_age_q   <= frame_age_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          prfl_pkg::REG_MODE:      mode_q      <= cfg_wdata_i[0];
          prfl_pkg::REG_PAGE_SIZE: page_size_q <= cfg_wdata_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q        <= page_d;
    scan_idx_q    <= scan_idx_d;
    hit_found_q   <= hit_found_d;
    hit_idx_q     <= hit_idx_d;
    empty_found_q <= empty_found_d;
    empty_idx_q   <= empty_idx_d;
    best_age_q    <= best_age_d;
    best_idx_q    <= best_idx_d;
    best_page_q   <= best_page_d;
    ptr_page_q    <= ptr_page_d;
    hit_q         <= hit_d;
    frame_q       <= frame_d;
    out_page_q    <= out_page_d;
    ev_valid_q    <= ev_valid_d;
    ev_page_q     <= ev_page_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_o         = prfl_pkg::FRAME_W'(frame_q);
  assign page_o          = out_page_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = faults_q;

  a_accept_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DIV)
    else $error("Accepted word did not start the divider.");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("Divider finished outside the divide step.");

  a_scan_to_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && scan_last |=> state_q == ST_UPD)
    else $error("Frame scan did not end in the update step.");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("A hit reported an eviction.");

  a_faults_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    faults_q >= $past(faults_q))
    else $error("Fault counter decreased.");

endmodule
